@@ design/fasi_pkg.sv @@
// ----------------------------------------------------------------------------
// Four-axis stepper interpolator package
// Shared axis count and the half-step coil table.
// ----------------------------------------------------------------------------
package fasi_pkg;

  localparam int unsigned AXES = 4;

  function automatic logic [3:0] coil_pattern(input logic [2:0] phase);
    logic [3:0] pat;
    begin
      case (phase)
        3'd0: pat = 4'h8;
        3'd1: pat = 4'hC;
        3'd2: pat = 4'h4;
        3'd3: pat = 4'h6;
        3'd4: pat = 4'h2;
        3'd5: pat = 4'h3;
        3'd6: pat = 4'h1;
        3'd7: pat = 4'h9;
        default: pat = 4'h0;
      endcase
      return pat;
    end
  endfunction

endpackage

@@ design/fasi_if.sv @@
// ----------------------------------------------------------------------------
// Four-axis stepper interpolator channels
// Move and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fasi_in_if #(
  parameter int unsigned STEP_BITS = 24,
  parameter int unsigned INTERVAL_BITS = 15
);
  logic valid;
  logic ready;
  logic cmd;
  logic signed [STEP_BITS-1:0] delta_x;
  logic signed [STEP_BITS-1:0] delta_y;
  logic signed [STEP_BITS-1:0] delta_z;
  logic signed [STEP_BITS-1:0] delta_e;
  logic [INTERVAL_BITS-1:0] interval_ticks;
  modport source (output valid, cmd, delta_x, delta_y, delta_z, delta_e, interval_ticks,
                  input ready);
  modport sink (input valid, cmd, delta_x, delta_y, delta_z, delta_e, interval_ticks,
                output ready);
endinterface

interface fasi_out_if;
  logic valid;
  logic ready;
  logic [3:0] coils_x;
  logic [3:0] coils_y;
  logic [3:0] coils_z;
  logic [3:0] coils_e;
  logic busy_res;
  logic done_res;
  logic rejected;
  modport source (output valid, coils_x, coils_y, coils_z, coils_e, busy_res, done_res,
                  rejected, input ready);
  modport sink (input valid, coils_x, coils_y, coils_z, coils_e, busy_res, done_res,
                rejected, output ready);
endinterface

@@ design/four_axis_stepper_interpolator.sv @@
// A start squares the four deltas, sums them and takes the integer square root as the length;
// an interpolation tick scales each axis in turn through one shared restoring divider,
// one quotient bit a cycle.
// Flow: one transaction at a time; the next is accepted once the result is taken.
// Reset: asynchronous, active low; all coils off, idle, all state cleared.
// ----------------------------------------------------------------------------
// Four-axis stepper interpolator
// Linear interpolation of four stepper axes with half-step coil drive.
// ----------------------------------------------------------------------------
module four_axis_stepper_interpolator #(
  parameter int unsigned STEP_BITS = 24,
  parameter int unsigned PHASE_COUNT = 8,
  parameter int unsigned INTERVAL_BITS = 15
) (
  input logic clk_i,
  input logic rst_ni,
  fasi_in_if.sink in_i,
  fasi_out_if.source out_o
);

  localparam int unsigned SB = STEP_BITS;
  localparam int unsigned MB = STEP_BITS;            // magnitude width
  localparam int unsigned SQB = 2 * MB + 2;          // sum of four squares
  localparam int unsigned LB = MB + 1;               // length width
  localparam int unsigned PB = MB + LB;              // product width
  localparam int unsigned RT = SQB / 2;              // root iterations
  localparam int unsigned NB = PB;                   // dividend bits
  localparam int unsigned CB = $clog2(NB + 1);
  localparam logic [2:0] PhLast = 3'(PHASE_COUNT - 1);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StSq   = 4'd1;
  localparam logic [3:0] StRoot = 4'd2;
  localparam logic [3:0] StTick = 4'd3;
  localparam logic [3:0] StMul  = 4'd4;
  localparam logic [3:0] StDiv  = 4'd5;
  localparam logic [3:0] StCmp  = 4'd6;
  localparam logic [3:0] StOut  = 4'd7;

  logic [3:0] state_q, state_d;
  logic signed [SB-1:0] delta_q [fasi_pkg::AXES];
  logic signed [SB:0] prog_q [fasi_pkg::AXES];
  logic [2:0] phase_q [fasi_pkg::AXES];
  logic [3:0] coil_q [fasi_pkg::AXES];
  logic [LB-1:0] len_q, idx_q;
  logic [INTERVAL_BITS-1:0] wait_q, ival_q;
  logic active_q, done_q, rej_q, end_q;
  logic [1:0] ax_q;
  logic [SQB-1:0] sum_q, rem_q, root_q, bit_q;
  logic [CB-1:0] cnt_q;
  logic [PB-1:0] num_q;        // dividend shift register, magnitude
  logic [LB:0] part_q;         // partial remainder
  logic [PB-1:0] quo_q;

  logic [MB-1:0] mag_w;
  logic [2*MB-1:0] sq_w;
  logic [LB:0] trial_w;
  logic last_w;

  always_comb begin
    mag_w = delta_q[ax_q][SB-1] ? MB'(-delta_q[ax_q]) : MB'(delta_q[ax_q]);
    sq_w = mag_w * mag_w;
    trial_w = {part_q[LB-1:0], num_q[PB-1]} - {1'b0, len_q};
    last_w = (ax_q == 2'd3) && end_q;
  end

  assign in_i.ready = (state_q == StIdle);
  assign out_o.valid = (state_q == StOut);
  assign out_o.coils_x = coil_q[0];
  assign out_o.coils_y = coil_q[1];
  assign out_o.coils_z = coil_q[2];
  assign out_o.coils_e = coil_q[3];
  assign out_o.busy_res = active_q;
  assign out_o.done_res = done_q;
  assign out_o.rejected = rej_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_i.valid) begin
        if (in_i.cmd && !active_q) state_d = StSq;
        else if (!in_i.cmd && active_q) state_d = StTick;
        else state_d = StOut;
      end
      StSq: if (ax_q == 2'd3) state_d = StRoot;
      StRoot: if (cnt_q == CB'(RT - 1)) state_d = StOut;
      StTick: begin
        if (len_q == '0 || wait_q < ival_q) state_d = StOut;
        else state_d = StMul;
      end
      StMul: state_d = StDiv;
      StDiv: if (cnt_q == CB'(NB - 1)) state_d = StCmp;
      StCmp: if (ax_q == 2'd3) state_d = StOut;
             else state_d = StMul;
      StOut: if (out_o.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      len_q <= '0;
      idx_q <= '0;
      wait_q <= '0;
      ival_q <= '0;
      active_q <= 1'b0;
      done_q <= 1'b0;
      rej_q <= 1'b0;
      end_q <= 1'b0;
      ax_q <= '0;
      cnt_q <= '0;
      sum_q <= '0;
      rem_q <= '0;
      root_q <= '0;
      bit_q <= '0;
      num_q <= '0;
      part_q <= '0;
      quo_q <= '0;
      for (int a = 0; a < fasi_pkg::AXES; a++) begin
        delta_q[a] <= '0;
        prog_q[a] <= '0;
        phase_q[a] <= '0;
        coil_q[a] <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: if (in_i.valid) begin
          done_q <= 1'b0;
          rej_q <= in_i.cmd && active_q;
          ax_q <= '0;
          cnt_q <= '0;
          sum_q <= '0;
          if (in_i.cmd && !active_q) begin
            delta_q[0] <= in_i.delta_x;
            delta_q[1] <= in_i.delta_y;
            delta_q[2] <= in_i.delta_z;
            delta_q[3] <= in_i.delta_e;
            for (int a = 0; a < fasi_pkg::AXES; a++) prog_q[a] <= '0;
            ival_q <= in_i.interval_ticks;
            idx_q <= '0;
            wait_q <= '0;
            active_q <= 1'b1;
          end
        end
        StSq: begin
          sum_q <= sum_q + SQB'(sq_w);
          ax_q <= ax_q + 2'd1;
          rem_q <= sum_q + SQB'(sq_w);
          root_q <= '0;
          bit_q <= SQB'(1) << (2 * (RT - 1));
        end
        StRoot: begin
          cnt_q <= cnt_q + CB'(1);
          if (rem_q >= root_q + bit_q) begin
            rem_q <= rem_q - (root_q + bit_q);
            root_q <= (root_q >> 1) + bit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (cnt_q == CB'(RT - 1)) begin
            len_q <= (rem_q >= root_q + bit_q) ? LB'((root_q >> 1) + bit_q)
                                               : LB'(root_q >> 1);
          end
        end
        StTick: begin
          ax_q <= '0;
          end_q <= 1'b0;
          if (len_q == '0) begin
            active_q <= 1'b0;
            idx_q <= '0;
            wait_q <= '0;
            done_q <= 1'b1;
            for (int a = 0; a < fasi_pkg::AXES; a++) coil_q[a] <= '0;
          end else if (wait_q < ival_q) begin
            wait_q <= wait_q + INTERVAL_BITS'(1);
            for (int a = 0; a < fasi_pkg::AXES; a++) coil_q[a] <= '0;
          end else begin
            wait_q <= '0;
            end_q <= (idx_q >= len_q);
          end
        end
        StMul: begin
          num_q <= PB'(mag_w) * PB'(idx_q);
          part_q <= '0;
          quo_q <= '0;
          cnt_q <= '0;
        end
        StDiv: begin
          cnt_q <= cnt_q + CB'(1);
          num_q <= num_q << 1;
          if (!trial_w[LB]) begin
            part_q <= trial_w;
            quo_q <= {quo_q[PB-2:0], 1'b1};
          end else begin
            part_q <= {part_q[LB-1:0], num_q[PB-1]};
            quo_q <= {quo_q[PB-2:0], 1'b0};
          end
        end
        StCmp: begin
          ax_q <= ax_q + 2'd1;
          if (!delta_q[ax_q][SB-1] && delta_q[ax_q] != '0 &&
              quo_q > PB'($unsigned(prog_q[ax_q]))) begin
            prog_q[ax_q] <= prog_q[ax_q] + (SB+1)'(1);
            phase_q[ax_q] <= (phase_q[ax_q] == PhLast) ? 3'd0 : phase_q[ax_q] + 3'd1;
            if (!last_w) begin
              coil_q[ax_q] <= fasi_pkg::coil_pattern(
                  (phase_q[ax_q] == PhLast) ? 3'd0 : phase_q[ax_q] + 3'd1);
            end
          end else if (delta_q[ax_q][SB-1] &&
                       quo_q > PB'($unsigned(-prog_q[ax_q]))) begin
            prog_q[ax_q] <= prog_q[ax_q] - (SB+1)'(1);
            phase_q[ax_q] <= (phase_q[ax_q] == 3'd0) ? PhLast : phase_q[ax_q] - 3'd1;
            if (!last_w) begin
              coil_q[ax_q] <= fasi_pkg::coil_pattern(
                  (phase_q[ax_q] == 3'd0) ? PhLast : phase_q[ax_q] - 3'd1);
            end
          end
          if (ax_q == 2'd3) begin
            if (end_q) begin
              active_q <= 1'b0;
              idx_q <= '0;
              done_q <= 1'b1;
              for (int a = 0; a < fasi_pkg::AXES; a++) coil_q[a] <= '0;
            end else begin
              idx_q <= idx_q + LB'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
